### rtl/grid_mesh_normals_core_defines.svh
// ---------------------------------------------------------------------------
// Grid mesh normals assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef GRID_MESH_NORMALS_CORE_DEFINES_SVH
`define GRID_MESH_NORMALS_CORE_DEFINES_SVH

// Same-cycle implication.
`define GMN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GMN_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gmn_pkg.sv
// ---------------------------------------------------------------------------
// Grid mesh normals package
// Sizes, codes and the command and status words between control and datapath.
// ---------------------------------------------------------------------------
package gmn_pkg;

   // Grid storage geometry.
   localparam int MAX_COLS    = 64;
   localparam int MAX_ROWS    = 64;
   localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Field and arithmetic widths.
   localparam int IDX_W   = 6;
   localparam int DIM_W   = 7;
   localparam int COORD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int PROD_W  = 65;
   localparam int CROSS_W = 67;
   localparam int MAG_W   = 66;
   localparam int M_W     = 16;
   localparam int SQ_W    = 32;
   localparam int SSUM_W  = 34;
   localparam int REM_W   = 35;
   localparam int QUO_W   = 31;
   localparam int ROOT_W  = 32;
   localparam int NRM_W   = 16;
   localparam int ACC_W   = 18;
   localparam int AVG_W   = 17;
   localparam int CNT_W   = 3;

   // Iteration counts of the serial units.
   localparam int MUL_STEPS  = DIFF_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int SQRT_STEPS = 16;
   localparam int STEP_W     = $clog2(MUL_STEPS);

   // Top weight of the square root and the reciprocal of three.
   localparam logic [ROOT_W-1:0] SQRT_TOP    = ROOT_W'(1) << (2 * SQRT_STEPS - 2);
   localparam logic [AVG_W-1:0]  RECIP3      = AVG_W'(43691);
   localparam int                RECIP3_SHIFT = 17;

   // Request operations.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_COLS = 2'd0;
   localparam logic [1:0] CSR_ROWS = 2'd1;
   localparam logic [1:0] CSR_MODE = 2'd2;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FACES = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   // Datapath operations.
   typedef enum logic [4:0] {
      DOP_NONE, DOP_CLEAR, DOP_CAPTURE, DOP_MUL_INIT, DOP_MUL_STEP, DOP_MUL_ACC,
      DOP_MAG, DOP_NORM, DOP_SQUARE, DOP_SUM, DOP_DIV_INIT, DOP_DIV_STEP,
      DOP_SQRT_INIT, DOP_SQRT_STEP, DOP_ACCUM, DOP_FACE_DONE, DOP_AVG, DOP_LOAD_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] idx;
      status_type status;
      logic       use_avg;
   } dp_cmd_type;

   typedef struct packed {
      logic zero;
      logic norm_ok;
   } dp_stat_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vertex_type;

endpackage

### rtl/gmn_vstore.sv
// ---------------------------------------------------------------------------
// Grid mesh normals vertex store
// One write port and one registered read port over all grid vertices.
// ---------------------------------------------------------------------------
module gmn_vstore import gmn_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  vertex_type        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output vertex_type        rd_data
);

   vertex_type mem [STORE_DEPTH];
   vertex_type rd_data_ff;

   // Write first port, registered read on the second.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/gmn_dp.sv
// ---------------------------------------------------------------------------
// Grid mesh normals datapath
// Quad diagonals, serial cross product, scaling, divider, square root and
// averaging, stepped one operation per cycle by the controller.
// ---------------------------------------------------------------------------
`include "grid_mesh_normals_core_defines.svh"

module gmn_dp import gmn_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_stat_type             stat,
   input  vertex_type              rd_data,
   output logic [1:0]              out_status,
   output logic signed [NRM_W-1:0] out_nx,
   output logic signed [NRM_W-1:0] out_ny,
   output logic signed [NRM_W-1:0] out_nz
);

   logic signed [COORD_W-1:0] vtx_ff [4][3];
   logic signed [DIFF_W-1:0]  v1 [3];
   logic signed [DIFF_W-1:0]  v2 [3];
   logic signed [DIFF_W-1:0]  op_a;
   logic signed [DIFF_W-1:0]  op_b;
   logic [PROD_W-1:0]         mcand_ff;
   logic [DIFF_W-1:0]         mplier_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic                      pneg_ff;
   logic signed [CROSS_W-1:0] sprod;
   logic signed [CROSS_W-1:0] cr_ff [3];
   logic [MAG_W-1:0]          mag_ff [3];
   logic                      neg_ff [3];
   logic [MAG_W-1:0]          or_all;
   logic [SQ_W-1:0]           sq_ff [3];
   logic [SSUM_W-1:0]         s_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [REM_W-1:0]          rem_sh;
   logic                      rem_ge;
   logic                      dbit_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic [ROOT_W-1:0]         x_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic [ROOT_W-1:0]         bit_ff;
   logic [ROOT_W-1:0]         root_try;
   logic [AVG_W-1:0]          round_sum;
   logic [NRM_W-1:0]          kmag;
   logic signed [ACC_W-1:0]   sum_ff [3];
   logic [CNT_W-1:0]          cnt_ff;
   logic [AVG_W-1:0]          avg_a;
   logic [AVG_W-1:0]          avg_q;
   logic [2*AVG_W-1:0]        avg_p;
   logic signed [NRM_W-1:0]   avg_ff [3];
   logic [1:0]                status_ff;
   logic signed [NRM_W-1:0]   nrm_ff [3];
   logic [1:0]                cidx;
   logic [1:0]                pidx;

   assign cidx = cmd.idx[1:0];
   assign pidx = cmd.idx[2:1];

   // Diagonals P11 - P00 and P10 - P01.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v1[i] = DIFF_W'(vtx_ff[3][i]) - DIFF_W'(vtx_ff[0][i]);
         v2[i] = DIFF_W'(vtx_ff[2][i]) - DIFF_W'(vtx_ff[1][i]);
      end
   end

   // Operand pair of each cross product term.
   always_comb begin
      unique case (cmd.idx)
         3'd0: begin op_a = v1[1]; op_b = v2[2]; end
         3'd1: begin op_a = v1[2]; op_b = v2[1]; end
         3'd2: begin op_a = v1[2]; op_b = v2[0]; end
         3'd3: begin op_a = v1[0]; op_b = v2[2]; end
         3'd4: begin op_a = v1[0]; op_b = v2[1]; end
         3'd5: begin op_a = v1[1]; op_b = v2[0]; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // Signed product and scaling status.
   assign sprod = pneg_ff ? -$signed(CROSS_W'(prod_ff)) : $signed(CROSS_W'(prod_ff));
   assign or_all = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign stat.zero = (or_all == '0);
   assign stat.norm_ok = (or_all[MAG_W-1:M_W] == '0);

   // Divider and square root step logic.
   assign rem_sh = {rem_ff[REM_W-2:0], dbit_ff};
   assign rem_ge = (rem_sh >= REM_W'(s_ff));
   assign root_try = root_ff + bit_ff;
   assign round_sum = AVG_W'(root_ff[AVG_W-1:0]) + AVG_W'(1);
   assign kmag = round_sum[AVG_W-1:1];

   // Average of the accumulated face normals, rounded half away from zero.
   always_comb begin
      avg_a = (sum_ff[cidx] < 0) ? AVG_W'(-sum_ff[cidx]) : AVG_W'(sum_ff[cidx]);
      avg_a = avg_a + AVG_W'(cnt_ff >> 1);
      avg_p = (2*AVG_W)'(avg_a) * (2*AVG_W)'(RECIP3);
      unique case (cnt_ff)
         3'd1:    avg_q = avg_a;
         3'd2:    avg_q = avg_a >> 1;
         3'd3:    avg_q = avg_p[RECIP3_SHIFT +: AVG_W];
         3'd4:    avg_q = avg_a >> 2;
         default: avg_q = '0;
      endcase
   end

   // Operation registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DOP_CLEAR: begin
            for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
            cnt_ff <= '0;
         end
         DOP_CAPTURE: begin
            vtx_ff[cidx][0] <= rd_data.x;
            vtx_ff[cidx][1] <= rd_data.y;
            vtx_ff[cidx][2] <= rd_data.z;
         end
         DOP_MUL_INIT: begin
            mcand_ff  <= PROD_W'(op_a[DIFF_W-1] ? DIFF_W'(-op_a) : DIFF_W'(op_a));
            mplier_ff <= op_b[DIFF_W-1] ? DIFF_W'(-op_b) : DIFF_W'(op_b);
            prod_ff   <= '0;
            pneg_ff   <= op_a[DIFF_W-1] ^ op_b[DIFF_W-1];
         end
         DOP_MUL_STEP: begin
            if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
         DOP_MUL_ACC: begin
            if (!cmd.idx[0]) cr_ff[pidx] <= sprod;
            else cr_ff[pidx] <= cr_ff[pidx] - sprod;
         end
         DOP_MAG: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= cr_ff[i][CROSS_W-1] ? MAG_W'(-cr_ff[i]) : MAG_W'(cr_ff[i]);
               neg_ff[i] <= cr_ff[i][CROSS_W-1];
            end
         end
         DOP_NORM: begin
            // Coarse steps while far above the 16-bit target, then single bits.
            for (int i = 0; i < 3; i++) begin
               if (or_all[MAG_W-1:24] != '0) mag_ff[i] <= mag_ff[i] >> 8;
               else mag_ff[i] <= mag_ff[i] >> 1;
            end
         end
         DOP_SQUARE: begin
            sq_ff[cidx] <= SQ_W'(mag_ff[cidx][M_W-1:0]) * SQ_W'(mag_ff[cidx][M_W-1:0]);
         end
         DOP_SUM: begin
            s_ff <= SSUM_W'(sq_ff[0]) + SSUM_W'(sq_ff[1]) + SSUM_W'(sq_ff[2]);
         end
         DOP_DIV_INIT: begin
            rem_ff  <= REM_W'(sq_ff[cidx][SQ_W-1:1]);
            dbit_ff <= sq_ff[cidx][0];
            quo_ff  <= '0;
         end
         DOP_DIV_STEP: begin
            rem_ff  <= rem_ge ? rem_sh - REM_W'(s_ff) : rem_sh;
            quo_ff  <= {quo_ff[QUO_W-2:0], rem_ge};
            dbit_ff <= 1'b0;
         end
         DOP_SQRT_INIT: begin
            x_ff    <= ROOT_W'(quo_ff);
            root_ff <= '0;
            bit_ff  <= SQRT_TOP;
         end
         DOP_SQRT_STEP: begin
            if (x_ff >= root_try) begin
               x_ff    <= x_ff - root_try;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         DOP_ACCUM: begin
            if (neg_ff[cidx]) sum_ff[cidx] <= sum_ff[cidx] - ACC_W'(kmag);
            else sum_ff[cidx] <= sum_ff[cidx] + ACC_W'(kmag);
         end
         DOP_FACE_DONE: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         DOP_AVG: begin
            avg_ff[cidx] <= (sum_ff[cidx] < 0) ? -NRM_W'(avg_q) : NRM_W'(avg_q);
         end
         DOP_LOAD_OUT: begin
            status_ff <= cmd.status;
            for (int i = 0; i < 3; i++) nrm_ff[i] <= cmd.use_avg ? avg_ff[i] : '0;
         end
         default: begin
         end
      endcase
   end

   assign out_status = status_ff;
   assign out_nx = nrm_ff[0];
   assign out_ny = nrm_ff[1];
   assign out_nz = nrm_ff[2];

   // Checks on the arithmetic sequence.
   `GMN_ASSERT_IMP(a_avg_count, cmd.op == DOP_AVG, cnt_ff != '0 && cnt_ff <= CNT_W'(4), "face count out of range at average")
   `GMN_ASSERT_IMP(a_root_range, cmd.op == DOP_ACCUM, root_ff <= ROOT_W'(32768), "square root above unit scale")
   `GMN_ASSERT_IMP(a_div_nonzero, cmd.op == DOP_DIV_STEP, s_ff != '0, "divide by zero sum of squares")

endmodule

### rtl/gmn_ctrl.sv
// ---------------------------------------------------------------------------
// Grid mesh normals controller
// Configuration registers, request decode, vertex addressing and the
// sequencer that steps the datapath through each face.
// ---------------------------------------------------------------------------
`include "grid_mesh_normals_core_defines.svh"

module gmn_ctrl import gmn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_op,
   input  logic [IDX_W-1:0]  req_row,
   input  logic [IDX_W-1:0]  req_col,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [DIM_W-1:0]  csr_data,
   output logic              rsp_valid,
   input  logic              rsp_tready,
   output logic              st_wr_en,
   output logic [ADDR_W-1:0] st_wr_addr,
   output logic [ADDR_W-1:0] st_rd_addr,
   output dp_cmd_type        cmd,
   input  dp_stat_type       stat
);

   typedef enum logic [17:0] {
      S_IDLE  = 18'h00001, S_SEL   = 18'h00002, S_FETCH = 18'h00004,
      S_MULI  = 18'h00008, S_MULS  = 18'h00010, S_MULA  = 18'h00020,
      S_MAG   = 18'h00040, S_NORM  = 18'h00080, S_SQ    = 18'h00100,
      S_SUM   = 18'h00200, S_DIVI  = 18'h00400, S_DIVS  = 18'h00800,
      S_SQI   = 18'h01000, S_SQS   = 18'h02000, S_ACC   = 18'h04000,
      S_FDONE = 18'h08000, S_AVG   = 18'h10000, S_OUT   = 18'h20000
   } state_type;

   state_type          state_ff, state_in;
   logic [DIM_W-1:0]   cols_ff, cols_in, rows_ff, rows_in;
   logic               mode_ff, mode_in, vmode_ff, vmode_in;
   logic [IDX_W-1:0]   row_ff, row_in, col_ff, col_in;
   logic [IDX_W-1:0]   fr_ff, fr_in, fc_ff, fc_in;
   logic [1:0]         cand_ff, cand_in, comp_ff, comp_in;
   logic [2:0]         prod_ff, prod_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0]   ec, er, sel_r, sel_c;
   logic               req_acc, out_free, in_grid, last, sel_ok;

   function automatic logic [ADDR_W-1:0] vaddr(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
      vaddr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
   endfunction

   // Effective grid size, clamped to the store.
   assign ec = (cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ff;
   assign er = (rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign in_grid    = (DIM_W'(req_row) < er) && (DIM_W'(req_col) < ec);
   assign st_wr_addr = vaddr(req_row, req_col);
   assign last       = !vmode_ff || (cand_ff == 2'd3);

   // Candidate face around the vertex; candidate bit low means one step back.
   always_comb begin
      if (!vmode_ff) begin
         sel_r  = DIM_W'(row_ff);
         sel_c  = DIM_W'(col_ff);
         sel_ok = 1'b1;
      end else begin
         sel_r  = DIM_W'(row_ff) - DIM_W'(!cand_ff[1]);
         sel_c  = DIM_W'(col_ff) - DIM_W'(!cand_ff[0]);
         sel_ok = !(!cand_ff[1] && row_ff == '0) && !(!cand_ff[0] && col_ff == '0)
                  && (sel_r < er - DIM_W'(1)) && (sel_c < ec - DIM_W'(1));
      end
   end

   // Vertex fetch order: P00, P01, P10, P11.
   assign st_rd_addr = vaddr(fr_ff + IDX_W'(step_ff[1]), fc_ff + IDX_W'(step_ff[0]));

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      mode_in  = mode_ff;
      vmode_in = vmode_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      fr_in    = fr_ff;
      fc_in    = fc_ff;
      cand_in  = cand_ff;
      comp_in  = comp_ff;
      prod_in  = prod_ff;
      step_in  = step_ff;
      st_wr_en = 1'b0;
      cmd      = '{op: DOP_NONE, idx: 3'd0, status: ST_OK, use_avg: 1'b0};

      // Register writes must arrive only while idle; the block itself does not enforce this.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COLS: cols_in = csr_data;
            CSR_ROWS: rows_in = csr_data;
            CSR_MODE: mode_in = csr_data[0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               cmd.op = DOP_LOAD_OUT;
               priority if (req_op == OP_WRITE) begin
                  st_wr_en   = in_grid;
                  cmd.status = in_grid ? ST_OK : ST_RANGE;
               end else if (ec < DIM_W'(2) || er < DIM_W'(2)) begin
                  cmd.status = ST_NO_FACES;
               end else if (!mode_ff && (DIM_W'(req_row) >= er - DIM_W'(1)
                                         || DIM_W'(req_col) >= ec - DIM_W'(1))) begin
                  cmd.status = ST_RANGE;
               end else if (mode_ff && !in_grid) begin
                  cmd.status = ST_RANGE;
               end else begin
                  cmd.op   = DOP_CLEAR;
                  row_in   = req_row;
                  col_in   = req_col;
                  vmode_in = mode_ff;
                  cand_in  = '0;
                  state_in = S_SEL;
               end
            end
         end
         S_SEL: begin
            priority if (sel_ok) begin
               fr_in    = sel_r[IDX_W-1:0];
               fc_in    = sel_c[IDX_W-1:0];
               step_in  = '0;
               state_in = S_FETCH;
            end else if (last) begin
               comp_in  = '0;
               state_in = S_AVG;
            end else begin
               cand_in = cand_ff + 2'd1;
            end
         end
         S_FETCH: begin
            if (step_ff != '0) begin
               cmd.op  = DOP_CAPTURE;
               cmd.idx = 3'(step_ff - STEP_W'(1));
            end
            if (step_ff == STEP_W'(4)) begin
               prod_in  = '0;
               state_in = S_MULI;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_MULI: begin
            cmd.op   = DOP_MUL_INIT;
            cmd.idx  = prod_ff;
            step_in  = '0;
            state_in = S_MULS;
         end
         S_MULS: begin
            cmd.op = DOP_MUL_STEP;
            if (step_ff == STEP_W'(MUL_STEPS - 1)) state_in = S_MULA;
            else step_in = step_ff + STEP_W'(1);
         end
         S_MULA: begin
            cmd.op  = DOP_MUL_ACC;
            cmd.idx = prod_ff;
            if (prod_ff == 3'd5) begin
               state_in = S_MAG;
            end else begin
               prod_in  = prod_ff + 3'd1;
               state_in = S_MULI;
            end
         end
         S_MAG: begin
            cmd.op   = DOP_MAG;
            state_in = S_NORM;
         end
         S_NORM: begin
            priority if (stat.zero) begin
               state_in = S_FDONE;
            end else if (stat.norm_ok) begin
               comp_in  = '0;
               state_in = S_SQ;
            end else begin
               cmd.op = DOP_NORM;
            end
         end
         S_SQ: begin
            cmd.op  = DOP_SQUARE;
            cmd.idx = 3'(comp_ff);
            if (comp_ff == 2'd2) state_in = S_SUM;
            else comp_in = comp_ff + 2'd1;
         end
         S_SUM: begin
            cmd.op   = DOP_SUM;
            comp_in  = '0;
            state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.op   = DOP_DIV_INIT;
            cmd.idx  = 3'(comp_ff);
            step_in  = '0;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            cmd.op = DOP_DIV_STEP;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = S_SQI;
            else step_in = step_ff + STEP_W'(1);
         end
         S_SQI: begin
            cmd.op   = DOP_SQRT_INIT;
            step_in  = '0;
            state_in = S_SQS;
         end
         S_SQS: begin
            cmd.op = DOP_SQRT_STEP;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_in = S_ACC;
            else step_in = step_ff + STEP_W'(1);
         end
         S_ACC: begin
            cmd.op  = DOP_ACCUM;
            cmd.idx = 3'(comp_ff);
            if (comp_ff == 2'd2) begin
               state_in = S_FDONE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_DIVI;
            end
         end
         S_FDONE: begin
            cmd.op = DOP_FACE_DONE;
            if (last) begin
               comp_in  = '0;
               state_in = S_AVG;
            end else begin
               cand_in  = cand_ff + 2'd1;
               state_in = S_SEL;
            end
         end
         S_AVG: begin
            cmd.op  = DOP_AVG;
            cmd.idx = 3'(comp_ff);
            if (comp_ff == 2'd2) state_in = S_OUT;
            else comp_in = comp_ff + 2'd1;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.op      = DOP_LOAD_OUT;
               cmd.status  = ST_OK;
               cmd.use_avg = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || (cmd.op == DOP_LOAD_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cols_ff      <= DIM_W'(2);
         rows_ff      <= DIM_W'(2);
         mode_ff      <= 1'b0;
         vmode_ff     <= 1'b0;
         cand_ff      <= '0;
         comp_ff      <= '0;
         prod_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         mode_ff      <= mode_in;
         vmode_ff     <= vmode_in;
         cand_ff      <= cand_in;
         comp_ff      <= comp_in;
         prod_ff      <= prod_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Address registers carry no reset.
   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      fr_ff  <= fr_in;
      fc_ff  <= fc_in;
   end

   // Checks on sequencing.
   `GMN_ASSERT_IMP(a_load_free, cmd.op == DOP_LOAD_OUT, !rsp_valid_ff || rsp_tready, "result overwritten before taken")
   `GMN_ASSERT_NXT(a_load_valid, cmd.op == DOP_LOAD_OUT, rsp_valid_ff, "loaded result not presented")
   `GMN_ASSERT_IMP(a_face_in_grid, state_ff == S_FETCH, DIM_W'(fr_ff) < er - DIM_W'(1) && DIM_W'(fc_ff) < ec - DIM_W'(1), "fetching a face outside the grid")

endmodule

### rtl/grid_mesh_normals_core.sv
// ---------------------------------------------------------------------------
// Grid mesh normals core
// Structured grid vertex store with face and averaged vertex normal output.
// ---------------------------------------------------------------------------
// Usage:
//   The req channel carries one word per item: tuser selects a vertex write
//   (0) or a normal read (1); tdata carries row, column and the Q16.16 vertex.
//   Every request word returns exactly one rsp word: tuser is the status,
//   tdata the three Q2.14 normal components (zero on writes and errors).
//   The csr channel sets grid_cols, grid_rows and per_vertex_mode; it is
//   always ready and must only be used while the core is idle.
//   Writes and error replies are registered and valid in the cycle after
//   acceptance. A face read runs four vertex fetches, six 33-step serial
//   multiplies for the cross product, scaling shifts until the magnitudes
//   fit in 16 bits, then per component a 31-step divide and a 16-step square
//   root on a shared unit, and the averaging and load of the result. A vertex
//   read repeats the face work for each of its one to four faces. One item
//   is processed at a time. Reset returns the grid to 2 by 2 in face mode;
//   stored vertices are undefined until written. When the receiver stalls
//   the result is held in the output register; a new request is taken once
//   that register is free or being emptied.
// ---------------------------------------------------------------------------
module grid_mesh_normals_core import gmn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // operation
   input  logic [111:0] req_tdata,   // row, col, vertex_x, vertex_y, vertex_z, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // status
   output logic [47:0]  rsp_tdata,   // normal_x, normal_y, normal_z
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [6:0]   csr_data
);

   logic              st_wr_en;
   logic [ADDR_W-1:0] st_wr_addr;
   logic [ADDR_W-1:0] st_rd_addr;
   vertex_type        st_wr_data;
   vertex_type        st_rd_data;
   dp_cmd_type        cmd;
   dp_stat_type       stat;
   logic signed [NRM_W-1:0] nx, ny, nz;

   // Unpack the request word.
   assign st_wr_data.x = req_tdata[43:12];
   assign st_wr_data.y = req_tdata[75:44];
   assign st_wr_data.z = req_tdata[107:76];

   gmn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_row    (req_tdata[5:0]),
      .req_col    (req_tdata[11:6]),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st_wr_en   (st_wr_en),
      .st_wr_addr (st_wr_addr),
      .st_rd_addr (st_rd_addr),
      .cmd        (cmd),
      .stat       (stat)
   );

   gmn_vstore u_vstore (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   gmn_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .rd_data    (st_rd_data),
      .out_status (rsp_tuser),
      .out_nx     (nx),
      .out_ny     (ny),
      .out_nz     (nz)
   );

   // Pack the result word.
   assign rsp_tdata = {nz, ny, nx};

endmodule

### tb/sv/tb_grid_mesh_normals_core.sv
// ---------------------------------------------------------------------------
// Grid mesh normals core testbench
// Drives vertex writes and normal reads under several grid settings, predicts
// each reply word with an in-bench normal calculator and checks every field.
// ---------------------------------------------------------------------------
module tb_grid_mesh_normals_core import gmn_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 20000000;

   typedef struct {
      logic        op;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } mesh_word_type;

   typedef struct {
      status_type  status;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
   } normal_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser = 1'b0;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;
   logic [47:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [6:0]   csr_data = '0;

   mesh_word_type   pending_words[$];
   normal_word_type expected_normals[$];
   int              errors = 0;
   int              cycles = 0;
   logic            hold_request = 1'b0;

   // Predictor state: the vertex store and the grid settings.
   logic signed [31:0] px[STORE_DEPTH];
   logic signed [31:0] py[STORE_DEPTH];
   logic signed [31:0] pz[STORE_DEPTH];
   bit                 written[STORE_DEPTH];
   int                 cfg_cols = 2;
   int                 cfg_rows = 2;
   int                 cfg_mode = 0;

   grid_mesh_normals_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned root_u64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint coord(int axis, int r, int c);
      int a;
      a = (r * MAX_COLS + c) % STORE_DEPTH;
      case (axis)
         0: return longint'(px[a]);
         1: return longint'(py[a]);
         default: return longint'(pz[a]);
      endcase
   endfunction

   // Unit normal of quad (r, c) from the cross product of its diagonals.
   function automatic void quad_normal(int r, int c, output int n[3]);
      logic signed [69:0] d1[3], d2[3], cr[3];
      logic [69:0]        mg[3];
      longint unsigned    m[3], s2, q;
      int                 len, sh, k;
      for (int i = 0; i < 3; i++) begin
         d1[i] = 70'(coord(i, r + 1, c + 1) - coord(i, r, c));
         d2[i] = 70'(coord(i, r + 1, c) - coord(i, r, c + 1));
      end
      cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
      cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
      cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
      len = 0;
      for (int i = 0; i < 3; i++) begin
         mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
         for (int b = 69; b >= 0; b--)
            if (mg[i][b] && b + 1 > len) len = b + 1;
      end
      n = '{0, 0, 0};
      if (len == 0) return;
      sh = len > 16 ? len - 16 : 0;
      s2 = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = 64'(mg[i] >> sh) & 64'hFFFF;
         s2 += m[i] * m[i];
      end
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] * m[i]) << 30) / s2;
         k = int'((root_u64(q) + 1) >> 1);
         n[i] = cr[i] < 0 ? -k : k;
      end
   endfunction

   // Predict the reply to one word, update the store and queue both.
   task automatic issue_word(logic op, int r, int c, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
      mesh_word_type   w;
      normal_word_type e;
      int ec, er, cnt, a, q;
      int sum[3], f[3];
      ec = cfg_cols > MAX_COLS ? MAX_COLS : cfg_cols;
      er = cfg_rows > MAX_ROWS ? MAX_ROWS : cfg_rows;
      e = '{ST_OK, 16'd0, 16'd0, 16'd0};
      sum = '{0, 0, 0};
      if (op == OP_WRITE) begin
         if (r >= er || c >= ec) begin
            e.status = ST_RANGE;
         end else begin
            a = r * MAX_COLS + c;
            px[a] = x;
            py[a] = y;
            pz[a] = z;
            written[a] = 1'b1;
         end
      end else if (ec < 2 || er < 2) begin
         e.status = ST_NO_FACES;
      end else if (cfg_mode == 0) begin
         if (r >= er - 1 || c >= ec - 1) begin
            e.status = ST_RANGE;
         end else begin
            quad_normal(r, c, f);
            e.nx = 16'(f[0]);
            e.ny = 16'(f[1]);
            e.nz = 16'(f[2]);
         end
      end else if (r >= er || c >= ec) begin
         e.status = ST_RANGE;
      end else begin
         // Average of the faces around the vertex, ties away from zero.
         cnt = 0;
         for (int fr = r - 1; fr <= r; fr++)
            for (int fc = c - 1; fc <= c; fc++)
               if (fr >= 0 && fc >= 0 && fr < er - 1 && fc < ec - 1) begin
                  quad_normal(fr, fc, f);
                  for (int i = 0; i < 3; i++) sum[i] += f[i];
                  cnt++;
               end
         for (int i = 0; i < 3; i++) begin
            a = sum[i] < 0 ? -sum[i] : sum[i];
            q = (a + cnt / 2) / cnt;
            f[i] = sum[i] < 0 ? -q : q;
         end
         e.nx = 16'(f[0]);
         e.ny = 16'(f[1]);
         e.nz = 16'(f[2]);
      end
      w = '{op, r[5:0], c[5:0], x, y, z};
      pending_words.push_back(w);
      expected_normals.push_back(e);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 131072)) - 65536);
         2: return 32'($signed($urandom_range(0, 512)) - 256);
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
      endcase
   endfunction

   // Write any vertex of quad (r, c) that holds no data yet.
   task automatic fill_quad(int r, int c);
      for (int dr = 0; dr < 2; dr++)
         for (int dc = 0; dc < 2; dc++)
            if (!written[(r + dr) * MAX_COLS + c + dc])
               issue_word(OP_WRITE, r + dr, c + dc, rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic write_csr(logic [1:0] index, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[6:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_COLS: cfg_cols = value & 7'h7F;
         CSR_ROWS: cfg_rows = value & 7'h7F;
         default:  cfg_mode = value & 1;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_normals.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly in-range reads and writes, with some words anywhere in the index space.
   task automatic random_phase(int count);
      int ec, er, r, c;
      ec = cfg_cols > MAX_COLS ? MAX_COLS : cfg_cols;
      er = cfg_rows > MAX_ROWS ? MAX_ROWS : cfg_rows;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 9) < 8 ? $urandom_range(0, er) : $urandom_range(0, 63);
         c = $urandom_range(0, 9) < 8 ? $urandom_range(0, ec) : $urandom_range(0, 63);
         if (r > 63) r = 63;
         if (c > 63) c = 63;
         if ($urandom_range(0, 99) < 40) begin
            if (ec >= 2 && er >= 2) begin
               if (cfg_mode == 0 && r < er - 1 && c < ec - 1) begin
                  fill_quad(r, c);
               end else if (cfg_mode == 1 && r < er && c < ec) begin
                  for (int fr = r - 1; fr <= r; fr++)
                     for (int fc = c - 1; fc <= c; fc++)
                        if (fr >= 0 && fc >= 0 && fr < er - 1 && fc < ec - 1)
                           fill_quad(fr, fc);
               end
            end
            issue_word(OP_READ, r, c, $urandom(), $urandom(), $urandom());
         end else begin
            issue_word(OP_WRITE, r, c, rand_coord(), rand_coord(), rand_coord());
         end
      end
   endtask

   task automatic set_grid(int cols, int rows, int mode);
      write_csr(CSR_COLS, cols);
      write_csr(CSR_ROWS, rows);
      write_csr(CSR_MODE, mode);
   endtask

   // Sender: bursts of words from the pending queue with random gaps.
   always @(posedge clock) begin
      static int burst_left = 1;
      static int gap_left = 0;
      mesh_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0 || pending_words.size() == 0) begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            w = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= w.op;
            req_tdata  <= {4'b0, w.z, w.y, w.x, w.col, w.row};
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Receiver: stall pattern that changes style, plus one long hold-off.
   always @(posedge clock) begin
      static int hold_left = 0;
      static bit hold_taken = 0;
      static int style = 0;
      static int style_left = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1;
            hold_left = 3000;
         end
         if (style_left == 0) begin
            style = $urandom_range(0, 2);
            style_left = $urandom_range(20, 300);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 3) != 0;
               default: rsp_tready <= $urandom_range(0, 3) == 0;
            endcase
         end
      end
   end

   // Check each reply word against the oldest prediction.
   always @(posedge clock) begin
      normal_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_normals.size() == 0) begin
            $error("reply word with no request outstanding");
            errors++;
         end else begin
            e = expected_normals.pop_front();
            if (rsp_tuser != e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[15:0] != e.nx) begin
               $error("normal_x: expected %0d, got %0d", $signed(e.nx),
                      $signed(rsp_tdata[15:0]));
               errors++;
            end
            if (rsp_tdata[31:16] != e.ny) begin
               $error("normal_y: expected %0d, got %0d", $signed(e.ny),
                      $signed(rsp_tdata[31:16]));
               errors++;
            end
            if (rsp_tdata[47:32] != e.nz) begin
               $error("normal_z: expected %0d, got %0d", $signed(e.nz),
                      $signed(rsp_tdata[47:32]));
               errors++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL grid_mesh_normals_core");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset grid is 2 by 2 in face mode: extreme corners, then a flat quad.
      issue_word(OP_WRITE, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      issue_word(OP_WRITE, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      issue_word(OP_WRITE, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      issue_word(OP_WRITE, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      issue_word(OP_READ, 0, 0, '0, '0, '0);
      issue_word(OP_READ, 1, 0, '0, '0, '0);
      issue_word(OP_READ, 0, 1, '1, '1, '1);
      issue_word(OP_READ, 63, 63, '0, '0, '0);
      issue_word(OP_WRITE, 2, 0, 32'h1234_5678, 32'h1, 32'h2);
      issue_word(OP_WRITE, 63, 63, '1, '1, '1);
      // Coincident vertices give a zero cross product.
      for (int i = 0; i < 4; i++)
         issue_word(OP_WRITE, i / 2, i % 2, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      issue_word(OP_READ, 0, 0, '0, '0, '0);
      issue_word(OP_WRITE, 1, 1, 32'h0001_0000, 32'h0003_0000, 32'h0003_0000);
      issue_word(OP_READ, 0, 0, '0, '0, '0);
      wait_drained();

      // No faces: a single column still accepts writes.
      set_grid(1, 5, 0);
      issue_word(OP_READ, 0, 0, '0, '0, '0);
      issue_word(OP_WRITE, 4, 0, 32'h0000_4000, 32'h0, 32'h0);
      issue_word(OP_WRITE, 0, 1, 32'h0, 32'h0, 32'h0);
      wait_drained();
      set_grid(2, 2, 1);
      issue_word(OP_READ, 1, 1, '0, '0, '0);
      issue_word(OP_READ, 2, 1, '0, '0, '0);
      wait_drained();

      // Long receiver hold-off during a stream of reads and writes.
      set_grid(4, 4, 0);
      hold_request <= 1'b1;
      random_phase(60);
      wait_drained();

      set_grid(3, 3, 1);   random_phase(120); wait_drained();
      set_grid(64, 64, 0); random_phase(120); wait_drained();
      set_grid(127, 127, 1); random_phase(60); wait_drained();
      set_grid(0, 0, 0);   random_phase(30);  wait_drained();
      set_grid(5, 1, 1);   random_phase(40);  wait_drained();
      set_grid(2, 64, 1);  random_phase(80);  wait_drained();
      set_grid(64, 2, 0);  random_phase(80);  wait_drained();
      // Shrinking the row length keeps stored vertices where they were.
      set_grid(3, 6, 0);   random_phase(80);  wait_drained();
      set_grid(6, 3, 0);   random_phase(80);  wait_drained();
      for (int p = 0; p < 7; p++) begin
         set_grid($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(0, 1));
         random_phase(80);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("PASS grid_mesh_normals_core");
      end else begin
         $display("FAIL grid_mesh_normals_core");
      end
      $finish;
   end

endmodule
